// ===== hw/rtl/muxed_input_scan_debouncer_defines.svh =====
`ifndef MUXED_INPUT_SCAN_DEBOUNCER_DEFINES_SVH
`define MUXED_INPUT_SCAN_DEBOUNCER_DEFINES_SVH

// Checks that prop holds in the same cycle whenever cond holds.
`define MSD_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("scan debouncer check failed");

// Checks that prop holds in the cycle after cond holds.
`define MSD_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("scan debouncer check failed");

`endif

// ===== hw/rtl/msd_pkg.sv =====
package msd_pkg;

   // Fixed field widths.
   localparam int unsigned PIN_COUNT  = 16;
   localparam int unsigned WORD_W     = 64;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned BOARD_W    = 4;
   localparam int unsigned BOARD_BITS = 16;
   localparam int unsigned CSR_IDX_W  = 2;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPTURE_PERIOD = 2'd0,
      CSR_SETTLE_TICKS   = 2'd1,
      CSR_BOARD_ENABLE   = 2'd2,
      CSR_INITIAL_LEVEL  = 2'd3
   } csr_reg_type;

   // Scanner mode; the scan phases share their low two bits with the phase number.
   typedef enum logic [2:0] {
      MODE_SCAN0    = 3'd0,
      MODE_SCAN1    = 3'd1,
      MODE_SCAN2    = 3'd2,
      MODE_SCAN3    = 3'd3,
      MODE_DEBOUNCE = 3'd4,
      MODE_WAIT     = 3'd5
   } mode_type;

   // Microprogram steps.
   typedef enum logic [2:0] {
      STEP_DISPATCH = 3'd0,
      STEP_TICK     = 3'd1,
      STEP_DB_ACC   = 3'd2,
      STEP_DB_APPLY = 3'd3,
      STEP_EMIT     = 3'd4
   } step_type;

   // Datapath operations.
   typedef enum logic [2:0] {
      OP_ACC_CLR = 3'd0,
      OP_TICK    = 3'd1,
      OP_ACC     = 3'd2,
      OP_APPLY   = 3'd3,
      OP_EMIT    = 3'd4
   } op_type;

   // Sequencer jump kinds.
   typedef enum logic [2:0] {
      JMP_NEXT     = 3'd0,
      JMP_GOTO     = 3'd1,
      JMP_DISPATCH = 3'd2,
      JMP_LOOP     = 3'd3,
      JMP_EMIT     = 3'd4
   } jump_type;

   typedef struct packed {
      logic     accept;
      op_type   op;
      jump_type jump;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic mode_debounce;
      logic acc_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic                 wen;
      logic [CSR_IDX_W-1:0] index;
      logic [WORD_W-1:0]    wdata;
   } csr_write_type;

   // Microprogram store: one control word per step.
   function automatic ctrl_word_type ucode_word(input step_type step);
      ctrl_word_type w;
      w = '{accept: 1'b0, op: OP_ACC_CLR, jump: JMP_GOTO, target: STEP_DISPATCH};
      unique case (step)
         STEP_DISPATCH: w = '{accept: 1'b1, op: OP_ACC_CLR, jump: JMP_DISPATCH,
                              target: STEP_DB_ACC};
         STEP_TICK:     w = '{accept: 1'b0, op: OP_TICK, jump: JMP_GOTO,
                              target: STEP_EMIT};
         STEP_DB_ACC:   w = '{accept: 1'b0, op: OP_ACC, jump: JMP_LOOP,
                              target: STEP_DB_ACC};
         STEP_DB_APPLY: w = '{accept: 1'b0, op: OP_APPLY, jump: JMP_NEXT,
                              target: STEP_EMIT};
         STEP_EMIT:     w = '{accept: 1'b0, op: OP_EMIT, jump: JMP_EMIT,
                              target: STEP_DISPATCH};
         default:       w = '{accept: 1'b0, op: OP_ACC_CLR, jump: JMP_GOTO,
                              target: STEP_DISPATCH};
      endcase
      return w;
   endfunction

   // Places pin k into bit 4k+phase of a word.
   function automatic logic [WORD_W-1:0] spread_pins(input logic [PIN_COUNT-1:0] pins,
                                                     input logic [1:0] phase);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int k = 0; k < PIN_COUNT; k++) begin
         w[4*k + int'(phase)] = pins[k];
      end
      return w;
   endfunction

   // One 16-bit slice of the word per enabled board.
   function automatic logic [WORD_W-1:0] board_mask(input logic [BOARD_W-1:0] en);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int b = 0; b < BOARD_W; b++) begin
         m[BOARD_BITS*b +: BOARD_BITS] = {BOARD_BITS{en[b]}};
      end
      return m;
   endfunction

endpackage

// ===== hw/rtl/msd_req_if.sv =====
interface msd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          ms_tick;
   logic [msd_pkg::PIN_COUNT-1:0] pin_levels;

   modport source (output valid, ms_tick, pin_levels, input ready);
   modport sink (input valid, ms_tick, pin_levels, output ready);
endinterface

// ===== hw/rtl/msd_rsp_if.sv =====
interface msd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       select_a_pin;
   logic                       select_b_pin;
   logic [msd_pkg::WORD_W-1:0] debounced_word;
   logic                       debounce_ran;

   modport source (output valid, select_a_pin, select_b_pin, debounced_word, debounce_ran,
                   input ready);
   modport sink (input valid, select_a_pin, select_b_pin, debounced_word, debounce_ran,
                 output ready);
endinterface

// ===== hw/rtl/msd_sequencer.sv =====
module msd_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  msd_pkg::status_type    status,
   output msd_pkg::ctrl_word_type ctrl
);

   msd_pkg::step_type upc_ff;
   msd_pkg::step_type upc_in;
   msd_pkg::step_type step_next;

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= msd_pkg::STEP_DISPATCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

   // Control word fetch and jump resolution.
   always_comb begin
      ctrl      = msd_pkg::ucode_word(upc_ff);
      step_next = msd_pkg::step_type'(3'(upc_ff) + 3'd1);
      upc_in    = upc_ff;
      unique case (ctrl.jump)
         msd_pkg::JMP_NEXT: begin
            upc_in = step_next;
         end
         msd_pkg::JMP_GOTO: begin
            upc_in = ctrl.target;
         end
         msd_pkg::JMP_DISPATCH: begin
            if (status.req_valid) begin
               upc_in = status.mode_debounce ? ctrl.target : step_next;
            end
         end
         msd_pkg::JMP_LOOP: begin
            upc_in = status.acc_last ? step_next : ctrl.target;
         end
         msd_pkg::JMP_EMIT: begin
            if (status.out_free) begin
               upc_in = ctrl.target;
            end
         end
         default: begin
            upc_in = msd_pkg::STEP_DISPATCH;
         end
      endcase
   end

endmodule

// ===== hw/rtl/msd_datapath.sv =====
module msd_datapath #(
   parameter int unsigned RING_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  msd_pkg::ctrl_word_type        ctrl,
   input  msd_pkg::csr_write_type        csr,
   input  logic                          req_valid,
   input  logic                          req_ms_tick,
   input  logic [msd_pkg::PIN_COUNT-1:0] req_pin_levels,
   input  logic                          rsp_ready,
   output msd_pkg::status_type           status,
   output logic                          rsp_valid,
   output logic                          rsp_select_a_pin,
   output logic                          rsp_select_b_pin,
   output logic [msd_pkg::WORD_W-1:0]    rsp_debounced_word,
   output logic                          rsp_debounce_ran
);

   localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
   localparam logic [msd_pkg::CNT_W-1:0] CNT_MAX = '1;

   // Configuration.
   logic [msd_pkg::CNT_W-1:0]   period_ff, period_in;
   logic [msd_pkg::CNT_W-1:0]   settle_ticks_ff, settle_ticks_in;
   logic [msd_pkg::BOARD_W-1:0] board_en_ff, board_en_in;

   // Scanner state.
   msd_pkg::mode_type           mode_ff, mode_in;
   logic [msd_pkg::CNT_W-1:0]   ms_ff, ms_in;
   logic [msd_pkg::CNT_W-1:0]   settle_ff, settle_in;
   logic [msd_pkg::WORD_W-1:0]  asm_ff, asm_in;
   logic [msd_pkg::WORD_W-1:0]  ring_ff [RING_DEPTH];
   logic [msd_pkg::WORD_W-1:0]  ring_in [RING_DEPTH];
   logic [IDX_W-1:0]            widx_ff, widx_in;
   logic [msd_pkg::WORD_W-1:0]  image_ff, image_in;
   logic                        ran_ff, ran_in;

   // Debounce accumulators.
   logic [msd_pkg::WORD_W-1:0]  acc_or_ff, acc_or_in;
   logic [msd_pkg::WORD_W-1:0]  acc_and_ff, acc_and_in;
   logic [IDX_W-1:0]            ridx_ff, ridx_in;

   // Latched input item.
   logic                        ms_tick_ff, ms_tick_in;
   logic [msd_pkg::PIN_COUNT-1:0] pins_ff, pins_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        sel_a_ff, sel_a_in;
   logic                        sel_b_ff, sel_b_in;
   logic [msd_pkg::WORD_W-1:0]  word_ff, word_in;
   logic                        rsp_ran_ff, rsp_ran_in;

   logic [2:0]                  mode_bits;
   logic [1:0]                  phase;
   logic [msd_pkg::CNT_W-1:0]   ms_inc;
   logic [msd_pkg::CNT_W-1:0]   settle_inc;
   logic [msd_pkg::WORD_W-1:0]  sample_word;
   logic                        out_free;

   assign mode_bits   = 3'(mode_ff);
   assign phase       = mode_bits[2] ? 2'b11 : mode_bits[1:0];
   assign ms_inc      = (ms_tick_ff && (ms_ff != CNT_MAX)) ? ms_ff + 1'b1 : ms_ff;
   assign settle_inc  = (settle_ff != CNT_MAX) ? settle_ff + 1'b1 : settle_ff;
   assign sample_word = asm_ff | msd_pkg::spread_pins(pins_ff, phase);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign status.req_valid     = req_valid;
   assign status.mode_debounce = (mode_ff == msd_pkg::MODE_DEBOUNCE);
   assign status.acc_last      = (ridx_ff == LAST_IDX);
   assign status.out_free      = out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_select_a_pin   = sel_a_ff;
   assign rsp_select_b_pin   = sel_b_ff;
   assign rsp_debounced_word = word_ff;
   assign rsp_debounce_ran   = rsp_ran_ff;

   // Next-state logic for configuration, item latch and the selected operation.
   always_comb begin
      period_in       = period_ff;
      settle_ticks_in = settle_ticks_ff;
      board_en_in     = board_en_ff;
      mode_in         = mode_ff;
      ms_in           = ms_ff;
      settle_in       = settle_ff;
      asm_in          = asm_ff;
      ring_in         = ring_ff;
      widx_in         = widx_ff;
      image_in        = image_ff;
      ran_in          = ran_ff;
      acc_or_in       = acc_or_ff;
      acc_and_in      = acc_and_ff;
      ridx_in         = ridx_ff;
      ms_tick_in      = ms_tick_ff;
      pins_in         = pins_ff;
      rsp_valid_in    = rsp_valid_ff;
      sel_a_in        = sel_a_ff;
      sel_b_in        = sel_b_ff;
      word_in         = word_ff;
      rsp_ran_in      = rsp_ran_ff;

      // Register writes; the preset reloads every ring entry and the image.
      if (csr.wen) begin
         case (csr.index)
            msd_pkg::CSR_CAPTURE_PERIOD: period_in = csr.wdata[msd_pkg::CNT_W-1:0];
            msd_pkg::CSR_SETTLE_TICKS:   settle_ticks_in = csr.wdata[msd_pkg::CNT_W-1:0];
            msd_pkg::CSR_BOARD_ENABLE:   board_en_in = csr.wdata[msd_pkg::BOARD_W-1:0];
            msd_pkg::CSR_INITIAL_LEVEL: begin
               for (int i = 0; i < RING_DEPTH; i++) begin
                  ring_in[i] = csr.wdata;
               end
               image_in = csr.wdata;
            end
            default: ;
         endcase
      end

      // Capture the item on its transfer.
      if (ctrl.accept && req_valid) begin
         ms_tick_in = req_ms_tick;
         pins_in    = req_pin_levels;
      end

      unique case (ctrl.op)
         msd_pkg::OP_ACC_CLR: begin
            acc_or_in  = '0;
            acc_and_in = '1;
            ridx_in    = '0;
         end
         msd_pkg::OP_TICK: begin
            ran_in = 1'b0;
            ms_in  = ms_inc;
            if (mode_ff == msd_pkg::MODE_WAIT) begin
               // Start a scan once the capture period has passed.
               if (ms_inc >= period_ff) begin
                  ms_in     = '0;
                  asm_in    = '0;
                  settle_in = '0;
                  mode_in   = msd_pkg::MODE_SCAN0;
               end
            end else if (!mode_bits[2]) begin
               // Scan phase: sample once the settle count is reached.
               settle_in = settle_inc;
               if (settle_inc >= settle_ticks_ff) begin
                  settle_in = '0;
                  if (mode_ff == msd_pkg::MODE_SCAN3) begin
                     ring_in[widx_ff] = sample_word & msd_pkg::board_mask(board_en_ff);
                     widx_in = (widx_ff == LAST_IDX) ? '0 : widx_ff + 1'b1;
                     asm_in  = '0;
                     mode_in = msd_pkg::MODE_DEBOUNCE;
                  end else begin
                     asm_in  = sample_word;
                     mode_in = msd_pkg::mode_type'(mode_bits + 3'd1);
                  end
               end
            end else begin
               mode_in = msd_pkg::MODE_WAIT;
            end
         end
         msd_pkg::OP_ACC: begin
            acc_or_in  = acc_or_ff | ring_ff[ridx_ff];
            acc_and_in = acc_and_ff & ring_ff[ridx_ff];
            ridx_in    = (ridx_ff == LAST_IDX) ? '0 : ridx_ff + 1'b1;
         end
         msd_pkg::OP_APPLY: begin
            // Clear bits low in every sample, set bits high in every sample.
            image_in = (image_ff & acc_or_ff) | acc_and_ff;
            ms_in    = '0;
            mode_in  = msd_pkg::MODE_WAIT;
            ran_in   = 1'b1;
         end
         msd_pkg::OP_EMIT: ;
         default: ;
      endcase

      // Result register: load on the emit step, clear after its transfer.
      if ((ctrl.op == msd_pkg::OP_EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
         sel_a_in     = ~phase[1];
         sel_b_in     = ~phase[0];
         word_in      = image_ff;
         rsp_ran_in   = ran_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and preset-bearing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= msd_pkg::CNT_W'(10);
         settle_ticks_ff <= msd_pkg::CNT_W'(1);
         board_en_ff     <= '1;
         mode_ff         <= msd_pkg::MODE_SCAN0;
         ms_ff           <= '0;
         settle_ff       <= '0;
         asm_ff          <= '0;
         widx_ff         <= '0;
         image_ff        <= '0;
         ran_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         period_ff       <= period_in;
         settle_ticks_ff <= settle_ticks_in;
         board_en_ff     <= board_en_in;
         mode_ff         <= mode_in;
         ms_ff           <= ms_in;
         settle_ff       <= settle_in;
         asm_ff          <= asm_in;
         widx_ff         <= widx_in;
         image_ff        <= image_in;
         ran_ff          <= ran_in;
         rsp_valid_ff    <= rsp_valid_in;
         ring_ff         <= ring_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_or_ff  <= acc_or_in;
      acc_and_ff <= acc_and_in;
      ridx_ff    <= ridx_in;
      ms_tick_ff <= ms_tick_in;
      pins_ff    <= pins_in;
      sel_a_ff   <= sel_a_in;
      sel_b_ff   <= sel_b_in;
      word_ff    <= word_in;
      rsp_ran_ff <= rsp_ran_in;
   end

endmodule

// ===== hw/rtl/muxed_input_scan_debouncer.sv =====
// A tick is taken in the dispatch step; a scan or wait tick then runs the tick and emit
// steps, and a debounce tick walks the sample ring one entry per cycle, then runs the
// apply and emit steps. The emit step registers the result and holds while one waits;
// the next tick is taken only once the sequencer is back in the dispatch step.
// Reset (synchronous): registers return to their defaults, ring and image to zero,
// the scanner starts in phase zero and the output register is empty.
`include "muxed_input_scan_debouncer_defines.svh"

module muxed_input_scan_debouncer #(
   parameter int unsigned RING_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   msd_req_if.sink                       req_chan,
   msd_rsp_if.source                     rsp_chan,
   input  logic                          csr_wen,
   input  logic [msd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [msd_pkg::WORD_W-1:0]    csr_wdata
);

   msd_pkg::ctrl_word_type ctrl;
   msd_pkg::status_type    status;
   msd_pkg::csr_write_type csr;

   assign csr.wen   = csr_wen;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // Items transfer only in the dispatch step.
   assign req_chan.ready = ctrl.accept;

   msd_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   msd_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .csr                (csr),
      .req_valid          (req_chan.valid),
      .req_ms_tick        (req_chan.ms_tick),
      .req_pin_levels     (req_chan.pin_levels),
      .rsp_ready          (rsp_chan.ready),
      .status             (status),
      .rsp_valid          (rsp_chan.valid),
      .rsp_select_a_pin   (rsp_chan.select_a_pin),
      .rsp_select_b_pin   (rsp_chan.select_b_pin),
      .rsp_debounced_word (rsp_chan.debounced_word),
      .rsp_debounce_ran   (rsp_chan.debounce_ran)
   );

   // After a transfer the sequencer leaves the dispatch step.
   `MSD_ASSERT_NEXT(a_leave_dispatch, req_chan.valid && req_chan.ready, !ctrl.accept)
   // An emit step with a free output register always produces a result.
   `MSD_ASSERT_NEXT(a_emit_loads, (ctrl.op == msd_pkg::OP_EMIT) && status.out_free, rsp_chan.valid)
   // A debounce result is reported with the select lines parked at phase three.
   `MSD_ASSERT_SAME(a_ran_parked, rsp_chan.valid && rsp_chan.debounce_ran,
                    !rsp_chan.select_a_pin && !rsp_chan.select_b_pin)

endmodule

// ===== tb/sv/muxed_input_scan_debouncer_tb.sv =====
`timescale 1ns / 1ps

module muxed_input_scan_debouncer_tb;

   localparam int RING_DEPTH = 4;

   // One result transfer of the block.
   typedef struct packed {
      logic                       select_a;
      logic                       select_b;
      logic [msd_pkg::WORD_W-1:0] word;
      logic                       ran;
   } scan_result_type;

   // How a phase of the run presets the ring and the debounced image.
   typedef enum int {PRESET_ZERO, PRESET_ONES, PRESET_RANDOM, PRESET_KEEP} preset_kind_type;

   // Ready patterns of the result receiver.
   typedef enum int {SINK_OPEN, SINK_THIRD, SINK_RANDOM, SINK_SPARSE} sink_pattern_type;

   // Tracks the scanner and the debounce ring, and holds the results still to come.
   class scan_scoreboard;
      logic [msd_pkg::CNT_W-1:0]   period_ms;
      logic [msd_pkg::CNT_W-1:0]   settle_len;
      logic [msd_pkg::BOARD_W-1:0] boards_on;
      logic [msd_pkg::WORD_W-1:0]  preset;

      msd_pkg::mode_type           mode;
      logic [msd_pkg::CNT_W-1:0]   ms_count;
      logic [msd_pkg::CNT_W-1:0]   settle_cnt;
      logic [msd_pkg::WORD_W-1:0]  assembling;
      logic [msd_pkg::WORD_W-1:0]  ring [RING_DEPTH];
      int                          ring_wr;
      logic [msd_pkg::WORD_W-1:0]  image;

      scan_result_type    scan_results_q[$];
      int                 errors;
      int                 ticks_noted;
      int                 results_checked;
      int                 debounce_results;

      function new();
         period_ms  = 16'd10;
         settle_len = 16'd1;
         boards_on  = 4'hF;
         preset     = '0;
         mode       = msd_pkg::MODE_SCAN0;
         ms_count   = '0;
         settle_cnt = '0;
         assembling = '0;
         ring_wr    = 0;
         foreach (ring[i]) ring[i] = '0;
         image      = '0;
         errors     = 0;
         ticks_noted = 0;
         results_checked = 0;
         debounce_results = 0;
      endfunction

      function int pending();
         return scan_results_q.size();
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
         end
      endfunction

      // A register write; a new preset reloads the ring and the image.
      function void write_reg(msd_pkg::csr_reg_type idx, logic [msd_pkg::WORD_W-1:0] value);
         case (idx)
            msd_pkg::CSR_CAPTURE_PERIOD: period_ms = value[msd_pkg::CNT_W-1:0];
            msd_pkg::CSR_SETTLE_TICKS:   settle_len = value[msd_pkg::CNT_W-1:0];
            msd_pkg::CSR_BOARD_ENABLE:   boards_on = value[msd_pkg::BOARD_W-1:0];
            msd_pkg::CSR_INITIAL_LEVEL: begin
               preset = value;
               foreach (ring[i]) ring[i] = value;
               image = value;
            end
            default: ;
         endcase
      endfunction

      // Advances the scanner by one accepted tick and queues the result it gives.
      function void note_tick(logic ms, logic [msd_pkg::PIN_COUNT-1:0] pins);
         scan_result_type            r;
         logic [msd_pkg::WORD_W-1:0] any_one;
         logic [msd_pkg::WORD_W-1:0] all_one;
         logic [msd_pkg::WORD_W-1:0] mask;
         logic [1:0]                 phase;
         logic                       ran;

         ran = 1'b0;
         ticks_noted++;
         if (mode == msd_pkg::MODE_DEBOUNCE) begin
            // Clear bits that are low in every sample, set bits high in every sample.
            any_one = '0;
            all_one = '1;
            foreach (ring[i]) begin
               any_one |= ring[i];
               all_one &= ring[i];
            end
            image    = (image & any_one) | all_one;
            ms_count = '0;
            mode     = msd_pkg::MODE_WAIT;
            ran      = 1'b1;
         end else begin
            if (ms && ms_count != 16'hFFFF) ms_count++;
            if (mode == msd_pkg::MODE_WAIT) begin
               if (ms_count >= period_ms) begin
                  ms_count   = '0;
                  assembling = '0;
                  settle_cnt = '0;
                  mode       = msd_pkg::MODE_SCAN0;
               end
            end else if (mode <= msd_pkg::MODE_SCAN3) begin
               if (settle_cnt != 16'hFFFF) settle_cnt++;
               if (settle_cnt >= settle_len) begin
                  // Sample the pins into this phase's bit of every nibble.
                  phase = mode[1:0];
                  for (int k = 0; k < msd_pkg::PIN_COUNT; k++) begin
                     if (pins[k]) assembling[4*k + int'(phase)] = 1'b1;
                  end
                  settle_cnt = '0;
                  if (mode == msd_pkg::MODE_SCAN3) begin
                     mask = '0;
                     for (int b = 0; b < msd_pkg::BOARD_W; b++) begin
                        if (boards_on[b]) begin
                           mask[msd_pkg::BOARD_BITS*b +: msd_pkg::BOARD_BITS] = '1;
                        end
                     end
                     ring[ring_wr] = assembling & mask;
                     ring_wr       = (ring_wr + 1) % RING_DEPTH;
                     assembling    = '0;
                     mode          = msd_pkg::MODE_DEBOUNCE;
                  end else begin
                     mode = msd_pkg::mode_type'(mode + 3'd1);
                  end
               end
            end else begin
               mode = msd_pkg::MODE_WAIT;
            end
         end

         // Outside a scan the select lines hold the last phase.
         phase      = (mode <= msd_pkg::MODE_SCAN3) ? mode[1:0] : 2'd3;
         r.select_a = ~phase[1];
         r.select_b = ~phase[0];
         r.word     = image;
         r.ran      = ran;
         scan_results_q.push_back(r);
      endfunction

      // Compares one result transfer with the oldest expected result.
      function void check_scan_result(logic sel_a, logic sel_b,
                                      logic [msd_pkg::WORD_W-1:0] word, logic ran);
         scan_result_type exp_r;

         results_checked++;
         if (ran) debounce_results++;
         if (scan_results_q.size() == 0) begin
            note_error($sformatf("result with nothing expected: a=%0b b=%0b word=%h ran=%0b",
                                 sel_a, sel_b, word, ran));
            return;
         end
         exp_r = scan_results_q.pop_front();
         if (exp_r.select_a !== sel_a || exp_r.select_b !== sel_b ||
             exp_r.word !== word || exp_r.ran !== ran) begin
            note_error($sformatf({"result mismatch: expected a=%0b b=%0b word=%h ran=%0b, ",
                                  "got a=%0b b=%0b word=%h ran=%0b"},
                                 exp_r.select_a, exp_r.select_b, exp_r.word, exp_r.ran,
                                 sel_a, sel_b, word, ran));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                          csr_wen;
   logic [msd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [msd_pkg::WORD_W-1:0]    csr_wdata;

   msd_req_if req_chan();
   msd_rsp_if rsp_chan();

   scan_scoreboard sb = new();

   int               burst_left;
   int               settings_used;
   int               stall_cnt;
   sink_pattern_type sink_pattern;

   muxed_input_scan_debouncer #(
      .RING_DEPTH(RING_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Overall limit on the run.
   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding.", sb.pending());
      $display("muxed_input_scan_debouncer_tb NOT OK");
      $finish;
   end

   // Receiver ready, following one of four patterns; the pattern is picked anew at random.
   initial begin
      rsp_chan.ready <= 1'b0;
      stall_cnt = 0;
      sink_pattern = SINK_OPEN;
      forever begin
         @(negedge clock);
         stall_cnt++;
         if (stall_cnt % 64 == 0) sink_pattern = sink_pattern_type'($urandom_range(0, 3));
         case (sink_pattern)
            SINK_OPEN:   rsp_chan.ready <= 1'b1;
            SINK_THIRD:  rsp_chan.ready <= (stall_cnt % 3 == 0);
            SINK_RANDOM: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default:     rsp_chan.ready <= (stall_cnt % 16 == 0);
         endcase
      end
   end

   // Every result transfer is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_scan_result(rsp_chan.select_a_pin, rsp_chan.select_b_pin,
                              rsp_chan.debounced_word, rsp_chan.debounce_ran);
      end
   end

   // Register write; entered and left at a falling edge.
   task automatic write_csr(input msd_pkg::csr_reg_type idx,
                            input logic [msd_pkg::WORD_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   // Offers one tick in bursts with gaps; entered and left at a falling edge.
   task automatic send_tick(input logic ms, input logic [msd_pkg::PIN_COUNT-1:0] pins);
      int gap;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end
      req_chan.valid      <= 1'b1;
      req_chan.ms_tick    <= ms;
      req_chan.pin_levels <= pins;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_tick(ms, pins);
      burst_left--;
      @(negedge clock);
   endtask

   // Waits for the block to drain, then applies a setting and sends random ticks.
   task automatic run_phase(input logic [msd_pkg::CNT_W-1:0]   period,
                            input logic [msd_pkg::CNT_W-1:0]   settle,
                            input logic [msd_pkg::BOARD_W-1:0] boards,
                            input preset_kind_type             preset_kind,
                            input int                          count,
                            input int                          ms_pct);
      logic [msd_pkg::PIN_COUNT-1:0] base;
      logic [msd_pkg::PIN_COUNT-1:0] pins;
      int                            pick;
      int                            flip;

      while (sb.pending() != 0) @(negedge clock);
      write_csr(msd_pkg::CSR_CAPTURE_PERIOD, msd_pkg::WORD_W'(period));
      write_csr(msd_pkg::CSR_SETTLE_TICKS, msd_pkg::WORD_W'(settle));
      write_csr(msd_pkg::CSR_BOARD_ENABLE, msd_pkg::WORD_W'(boards));
      case (preset_kind)
         PRESET_ZERO:   write_csr(msd_pkg::CSR_INITIAL_LEVEL, '0);
         PRESET_ONES:   write_csr(msd_pkg::CSR_INITIAL_LEVEL, '1);
         PRESET_RANDOM: write_csr(msd_pkg::CSR_INITIAL_LEVEL, {$urandom, $urandom});
         default: ;
      endcase
      settings_used++;

      // Mostly a steady pattern with the odd bounce, sometimes a new or wild pattern.
      base = msd_pkg::PIN_COUNT'($urandom);
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            pins = base;
            if ($urandom_range(0, 1) == 1) begin
               flip = $urandom_range(0, msd_pkg::PIN_COUNT - 1);
               pins[flip] = ~pins[flip];
            end
         end else if (pick == 7) begin
            pins = msd_pkg::PIN_COUNT'($urandom);
         end else if (pick == 8) begin
            base = msd_pkg::PIN_COUNT'($urandom);
            pins = base;
         end else begin
            pins = ~base;
         end
         send_tick(1'($urandom_range(0, 99) < ms_pct), pins);
      end
      req_chan.valid <= 1'b0;
   endtask

   // Stimulus.
   initial begin
      logic [msd_pkg::PIN_COUNT-1:0] directed_pins [8];

      directed_pins = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                        16'h0001, 16'h8000, 16'hF00F, 16'h0FF0};
      reset               <= 1'b1;
      csr_wen             <= 1'b0;
      csr_index           <= msd_pkg::CSR_CAPTURE_PERIOD;
      csr_wdata           <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.ms_tick    <= 1'b0;
      req_chan.pin_levels <= '0;
      burst_left    = 0;
      settings_used = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed ticks at reset settings: a full scan, a debounce, the wait and a rescan.
      for (int i = 0; i < 24; i++) begin
         send_tick((i >= 5) ? 1'b1 : 1'(i % 2), directed_pins[i % 8]);
      end
      req_chan.valid <= 1'b0;

      // Random phases, extremes of every register among them.
      run_phase(16'd1,     16'd1,     4'hF, PRESET_RANDOM, 250, 70);
      run_phase(16'd0,     16'd0,     4'h5, PRESET_ONES,   200, 50);
      run_phase(16'd3,     16'd2,     4'hA, PRESET_RANDOM, 200, 80);
      run_phase(16'hFFFF,  16'hFFFF,  4'h0, PRESET_ZERO,    40, 90);
      run_phase(16'd2,     16'd1,     4'h3, PRESET_KEEP,   200, 60);
      run_phase(16'd1,     16'd4,     4'hC, PRESET_RANDOM, 200, 75);
      run_phase(16'd0,     16'hFFFF,  4'h9, PRESET_KEEP,    30, 50);
      run_phase(16'd1,     16'd1,     4'hF, PRESET_RANDOM, 350, 70);

      // Drain, then allow for any stray result.
      while (sb.pending() != 0) @(negedge clock);
      repeat (RING_DEPTH + 8) @(negedge clock);

      $display("Transferred %0d ticks under %0d register settings.",
               sb.ticks_noted, settings_used);
      $display("Checked %0d results, %0d of them debounce steps; %0d errors, %0d missing.",
               sb.results_checked, sb.debounce_results, sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("muxed_input_scan_debouncer_tb OK");
      end else begin
         $display("muxed_input_scan_debouncer_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/msd_pkg.sv
hw/rtl/msd_req_if.sv
hw/rtl/msd_rsp_if.sv
hw/rtl/msd_sequencer.sv
hw/rtl/msd_datapath.sv
hw/rtl/muxed_input_scan_debouncer.sv
tb/sv/muxed_input_scan_debouncer_tb.sv
